FILE: sv/b2da_pkg.sv
// Package for the binary to decimal ASCII converter.
// Holds the item structs, the character codes and the width constants.
// Depends on nothing.
`default_nettype none

package b2da_pkg;

    // Width of the number that is converted.
    localparam int VALUE_BITS = 32;
    // Largest number of decimal digits that such a number can need.
    localparam int MAX_DIGITS = 10;
    localparam int BCD_BITS   = 4 * MAX_DIGITS;
    localparam int CNT_BITS   = $clog2(VALUE_BITS);
    localparam int IDX_BITS   = $clog2(MAX_DIGITS);

    // Buffer size register.
    localparam int           BUF_BITS  = 4;
    localparam logic [3:0]   BUF_RESET = 4'd11;

    // Character codes and request types.
    localparam logic [5:0]   CHAR_ZERO  = 6'd48;
    localparam logic [5:0]   CHAR_MINUS = 6'd45;
    localparam logic         REQ_UNSIGNED = 1'b0;
    localparam logic         REQ_SIGNED   = 1'b1;

    // Input item.
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  req_type;
    } t_in_item;

    // Result item: one character.
    typedef struct packed {
        logic [5:0] char_code;
        logic       last_char;
    } t_out_item;

endpackage

`default_nettype wire

FILE: sv/binary_to_decimal_ascii_unit.sv
// Binary to decimal ASCII converter, top level.
// Bit-serial double dabble followed by a digit-serial character emitter.
// Depends on b2da_pkg.
// After an item is accepted, the double dabble register shifts through every bit of
// the value, and a digit search step (ST_PREP) then finds the first digit to emit.
// A new item is taken only while idle. Each item emits 1 to 11 characters;
// busy stays high until the last character has gone out.
// The receiver cannot stall: each character is shown for exactly one cycle.
// Synchronous active-low reset returns the unit to idle and the buffer size to 11.
`default_nettype none

module binary_to_decimal_ascii_unit (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    start,
    output logic                   busy,
    input  b2da_pkg::t_in_item     i_item,
    output logic                   o_strobe,
    output b2da_pkg::t_out_item    o_result,
    input  wire                    i_cfg_we,
    input  wire [b2da_pkg::BUF_BITS-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_PREP = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state                            r_state, n_state;
    logic [b2da_pkg::VALUE_BITS-1:0]   r_bin, n_bin;
    logic [b2da_pkg::BCD_BITS-1:0]     r_bcd, n_bcd;
    logic [b2da_pkg::CNT_BITS-1:0]     r_cnt, n_cnt;
    logic [b2da_pkg::IDX_BITS-1:0]     r_idx, n_idx;
    logic                              r_neg, n_neg;
    logic [b2da_pkg::BUF_BITS-1:0]     r_buf_size;

    logic                              accept;
    logic                              in_neg;
    logic [b2da_pkg::BCD_BITS-1:0]     bcd_adj;
    logic [b2da_pkg::IDX_BITS-1:0]     msd;
    logic [b2da_pkg::IDX_BITS-1:0]     lim_m1;
    logic [3:0]                        cur_digit;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);
    assign in_neg = (i_item.req_type == b2da_pkg::REQ_SIGNED) &&
                    i_item.value[b2da_pkg::VALUE_BITS-1];

    // Add three to every BCD digit of five or more before the shift.
    always_comb begin
        bcd_adj = r_bcd;
        for (int d = 0; d < b2da_pkg::MAX_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                bcd_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end
        end
    end

    // Index of the most significant non-zero digit; zero when all are zero.
    always_comb begin
        msd = '0;
        for (int d = 1; d < b2da_pkg::MAX_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] != 4'd0) begin
                msd = b2da_pkg::IDX_BITS'(d);
            end
        end
    end

    // Highest digit index the buffer allows: the digit limit minus one.
    always_comb begin
        if (r_buf_size < 4'd2) begin
            lim_m1 = '0;
        end else if (r_buf_size > 4'(b2da_pkg::MAX_DIGITS + 1)) begin
            lim_m1 = b2da_pkg::IDX_BITS'(b2da_pkg::MAX_DIGITS - 1);
        end else begin
            lim_m1 = b2da_pkg::IDX_BITS'(r_buf_size - 4'd2);
        end
    end

    assign cur_digit = r_bcd[{r_idx, 2'b00} +: 4];

    // Result item, driven from registered state.
    always_comb begin
        o_strobe = (r_state == ST_EMIT);
        if (r_neg) begin
            o_result.char_code = b2da_pkg::CHAR_MINUS;
            o_result.last_char = 1'b0;
        end else begin
            o_result.char_code = b2da_pkg::CHAR_ZERO + {2'b00, cur_digit};
            o_result.last_char = (r_idx == '0);
        end
    end

    // Sequencer: load, shift, find the first digit, emit.
    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_neg   = r_neg;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_bin   = in_neg ? (~i_item.value + 1'b1) : i_item.value;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_neg   = in_neg;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                {n_bcd, n_bin} = {bcd_adj[b2da_pkg::BCD_BITS-2:0], r_bin, 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == b2da_pkg::CNT_BITS'(b2da_pkg::VALUE_BITS - 1)) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_idx   = (msd < lim_m1) ? msd : lim_m1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (r_neg) begin
                    n_neg = 1'b0;
                end else if (r_idx == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_neg      <= 1'b0;
            r_buf_size <= b2da_pkg::BUF_RESET;
        end else begin
            r_state <= n_state;
            r_neg   <= n_neg;
            if (i_cfg_we) begin
                r_buf_size <= i_cfg_data;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
        r_idx <= n_idx;
    end

    // Checks on the sequencer.
    a_accept_to_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_CONV && r_cnt == '0))
        else $error("Accepted item did not start conversion.");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_char) |=> !busy)
        else $error("Unit still busy after the last character.");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.char_code == b2da_pkg::CHAR_MINUS) |-> !o_result.last_char)
        else $error("Minus sign flagged as last character.");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (r_idx <= b2da_pkg::IDX_BITS'(b2da_pkg::MAX_DIGITS - 1)))
        else $error("Digit index beyond the BCD register.");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for binary_to_decimal_ascii_unit.
// Predicts the ASCII characters of each number in its own model and checks every strobe.
// Depends on b2da_pkg and binary_to_decimal_ascii_unit.
`default_nettype none

module tb;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    b2da_pkg::t_in_item            i_item;
    logic                          o_strobe;
    b2da_pkg::t_out_item           o_result;
    logic                          i_cfg_we;
    logic [b2da_pkg::BUF_BITS-1:0] i_cfg_data;

    // Characters still owed by the block, oldest first.
    b2da_pkg::t_out_item pending_chars[$];
    // Local copy of the buffer size register.
    logic [b2da_pkg::BUF_BITS-1:0] buffer_len;
    int error_count;
    // Sender burst state.
    int burst_left;

    binary_to_decimal_ascii_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the length of the run.
    initial begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Prints one mismatch and counts it.
    task automatic report_mismatch(input string what);
        error_count++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Queues the characters that one number should produce under the current buffer size.
    function automatic void queue_decimal_chars(input b2da_pkg::t_in_item item);
        logic [b2da_pkg::VALUE_BITS:0] mag;
        logic [3:0]                    digit [b2da_pkg::MAX_DIGITS];
        bit                            neg;
        int                            limit;
        int                            nd;
        b2da_pkg::t_out_item           ch;
        mag = {1'b0, item.value};
        neg = (item.req_type == b2da_pkg::REQ_SIGNED) &&
              item.value[b2da_pkg::VALUE_BITS-1];
        // The most negative value keeps its full magnitude in the wider vector.
        if (neg) begin
            mag = {1'b0, (~item.value + 1'b1)};
        end
        if (buffer_len < 2) begin
            limit = 1;
        end else if (buffer_len > b2da_pkg::MAX_DIGITS + 1) begin
            limit = b2da_pkg::MAX_DIGITS;
        end else begin
            limit = buffer_len - 1;
        end
        // Collect the low-order digits, at least one.
        nd = 0;
        do begin
            digit[nd] = 4'(mag % 10);
            nd++;
            mag = mag / 10;
        end while (mag > 0 && nd < limit);
        if (neg) begin
            ch.char_code = b2da_pkg::CHAR_MINUS;
            ch.last_char = 1'b0;
            pending_chars.push_back(ch);
        end
        while (nd > 0) begin
            nd--;
            ch.char_code = b2da_pkg::CHAR_ZERO + 6'(digit[nd]);
            ch.last_char = (nd == 0);
            pending_chars.push_back(ch);
        end
    endfunction

    // Compares each strobed character with the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character %0d last %0b",
                                          o_result.char_code, o_result.last_char));
            end else begin
                if (o_result.char_code !== pending_chars[0].char_code) begin
                    report_mismatch($sformatf("char_code %0d, expected %0d",
                                              o_result.char_code, pending_chars[0].char_code));
                end
                if (o_result.last_char !== pending_chars[0].last_char) begin
                    report_mismatch($sformatf("last_char %0b, expected %0b",
                                              o_result.last_char, pending_chars[0].last_char));
                end
                void'(pending_chars.pop_front());
            end
        end
    end

    // Offers one item from a falling edge and holds it until the block takes it.
    task automatic send_number(input logic [b2da_pkg::VALUE_BITS-1:0] value,
                               input logic req_type);
        bit taken;
        i_item.value    = value;
        i_item.req_type = req_type;
        start           = 1'b1;
        taken           = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            if (!busy) begin
                taken = 1'b1;
                queue_decimal_chars(i_item);
            end
        end
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // Waits until every owed character has arrived and the block is idle.
    task automatic wait_drained();
        while (pending_chars.size() != 0 || busy) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Writes the buffer size register while the block is idle.
    task automatic set_buffer_size(input logic [b2da_pkg::BUF_BITS-1:0] size);
        wait_drained();
        i_cfg_we   = 1'b1;
        i_cfg_data = size;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        buffer_len = size;
    endtask

    // Sender pacing: bursts of random length separated by random gaps.
    task automatic pace_sender();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            // Some bursts follow straight on, the rest after a gap that ends on a falling edge.
            if ($urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(1, 50)) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Random number drawn from several shapes so that all digit counts turn up.
    function automatic logic [b2da_pkg::VALUE_BITS-1:0] random_number();
        logic [b2da_pkg::VALUE_BITS-1:0] p;
        p = 1;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 99);
            2: begin
                repeat ($urandom_range(0, 9)) p = p * 10;
                return p + $urandom_range(0, 2) - 1;
            end
            3: return -$urandom_range(1, 1000);
            4: return 32'h8000_0000 + $urandom_range(0, 4) - 2;
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    // Boundary numbers at the reset buffer size.
    task automatic test_boundaries();
        send_number(32'd0, b2da_pkg::REQ_UNSIGNED);
        send_number(32'd0, b2da_pkg::REQ_SIGNED);
        send_number(32'd9, b2da_pkg::REQ_UNSIGNED);
        send_number(32'd10, b2da_pkg::REQ_SIGNED);
        send_number(32'hFFFF_FFFF, b2da_pkg::REQ_UNSIGNED);
        send_number(32'hFFFF_FFFF, b2da_pkg::REQ_SIGNED);
        send_number(32'h8000_0000, b2da_pkg::REQ_SIGNED);
        send_number(32'h8000_0000, b2da_pkg::REQ_UNSIGNED);
        send_number(32'h7FFF_FFFF, b2da_pkg::REQ_SIGNED);
        send_number(32'd1_000_000_000, b2da_pkg::REQ_UNSIGNED);
        send_number(32'd999_999_999, b2da_pkg::REQ_SIGNED);
    endtask

    // Truncation to the low-order digits and the out-of-range buffer sizes.
    task automatic test_digit_limits();
        set_buffer_size(4'd4);
        send_number(-32'sd123456, b2da_pkg::REQ_SIGNED);
        send_number(32'd123456, b2da_pkg::REQ_UNSIGNED);
        set_buffer_size(4'd2);
        send_number(32'd987, b2da_pkg::REQ_UNSIGNED);
        send_number(32'h8000_0000, b2da_pkg::REQ_SIGNED);
        set_buffer_size(4'd1);
        send_number(32'd45, b2da_pkg::REQ_UNSIGNED);
        set_buffer_size(4'd0);
        send_number(-32'sd76, b2da_pkg::REQ_SIGNED);
        send_number(32'd0, b2da_pkg::REQ_SIGNED);
        set_buffer_size(4'd15);
        send_number(32'hFFFF_FFFF, b2da_pkg::REQ_UNSIGNED);
        send_number(32'h8000_0000, b2da_pkg::REQ_SIGNED);
        set_buffer_size(4'd12);
        send_number(32'd4_000_000_001, b2da_pkg::REQ_UNSIGNED);
        set_buffer_size(4'd11);
        send_number(32'd1_234_567_890, b2da_pkg::REQ_UNSIGNED);
    endtask

    // Random numbers under a sequence of buffer sizes, with paced sending.
    task automatic test_random_traffic();
        logic [b2da_pkg::BUF_BITS-1:0] sizes [10];
        sizes = '{4'd11, 4'd5, 4'd2, 4'd15, 4'd0, 4'd7, 4'd1, 4'd12, 4'd3, 4'd11};
        for (int s = 0; s < 10; s++) begin
            set_buffer_size(sizes[s]);
            burst_left = 0;
            repeat (21) begin
                pace_sender();
                send_number(random_number(), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Reset, the tests in turn, then the drain and the verdict.
    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        buffer_len  = b2da_pkg::BUF_RESET;
        error_count = 0;
        burst_left  = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_boundaries();
        test_digit_limits();
        test_random_traffic();

        while (pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (60) @(posedge i_clk);
        if (pending_chars.size() != 0) begin
            report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
        end
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
sv/b2da_pkg.sv
sv/binary_to_decimal_ascii_unit.sv
tb/sv/tb.sv
